### hdl/cctm_pkg.sv
// Shared types, constants and microcode table for the cycle-count timestamp block.
package cctm_pkg;

	localparam int CNT_W     = 32;
	localparam int TS_W      = 64;
	localparam int MUL_W     = 20;
	localparam int PROD_W    = CNT_W + MUL_W;
	localparam int DVD_W     = PROD_W + 1;
	localparam int DIV_STEPS = DVD_W;
	localparam int STEP_W    = $clog2(DIV_STEPS);
	localparam int PC_W      = 4;
	localparam int ADDR_W    = 3;
	localparam int DATA_W    = 32;

	localparam logic [MUL_W-1:0] MICROS_PER_SEC    = MUL_W'(1000000);
	localparam logic [CNT_W-1:0] CORE_CLOCK_HZ_RST = CNT_W'(84000000);
	localparam logic             REG_CORE_CLOCK_HZ = 1'b0;
	localparam logic             CMD_INIT          = 1'b1;

	typedef logic [PC_W-1:0] pc_t;

	localparam pc_t PC_WAIT  = PC_W'(0);
	localparam pc_t PC_TCMD  = PC_W'(1);
	localparam pc_t PC_TINIT = PC_W'(2);
	localparam pc_t PC_MUL   = PC_W'(3);
	localparam pc_t PC_LOAD  = PC_W'(4);
	localparam pc_t PC_DIV   = PC_W'(5);
	localparam pc_t PC_ACCUM = PC_W'(6);
	localparam pc_t PC_INIT  = PC_W'(7);
	localparam pc_t PC_ZERO  = PC_W'(8);
	localparam pc_t PC_EMIT  = PC_W'(9);

	typedef enum logic [3:0] {
		OP_WAIT,
		OP_NOP,
		OP_MUL,
		OP_LOAD,
		OP_DIV,
		OP_ACCUM,
		OP_INIT,
		OP_ZERO,
		OP_EMIT
	} op_t;

	typedef enum logic [2:0] {
		C_NONE,
		C_NO_INPUT,
		C_CMD,
		C_NOT_INIT,
		C_DIV_MORE,
		C_OUT_BUSY
	} cond_t;

	typedef struct packed {
		op_t   op;
		cond_t cond;
		pc_t   jmp;
		pc_t   nxt;
	} ucode_t;

	typedef struct packed {
		logic in_valid;
		logic cmd;
		logic init;
		logic div_more;
		logic out_busy;
	} seq_stat_t;

	function automatic ucode_t ucode_rom(input pc_t pc);
		ucode_t w;
		unique case (pc)
			PC_WAIT:  w = '{OP_WAIT,  C_NO_INPUT, PC_WAIT, PC_TCMD};
			PC_TCMD:  w = '{OP_NOP,   C_CMD,      PC_INIT, PC_TINIT};
			PC_TINIT: w = '{OP_NOP,   C_NOT_INIT, PC_ZERO, PC_MUL};
			PC_MUL:   w = '{OP_MUL,   C_NONE,     PC_WAIT, PC_LOAD};
			PC_LOAD:  w = '{OP_LOAD,  C_NONE,     PC_WAIT, PC_DIV};
			PC_DIV:   w = '{OP_DIV,   C_DIV_MORE, PC_DIV,  PC_ACCUM};
			PC_ACCUM: w = '{OP_ACCUM, C_NONE,     PC_WAIT, PC_EMIT};
			PC_INIT:  w = '{OP_INIT,  C_NONE,     PC_WAIT, PC_EMIT};
			PC_ZERO:  w = '{OP_ZERO,  C_NONE,     PC_WAIT, PC_EMIT};
			PC_EMIT:  w = '{OP_EMIT,  C_OUT_BUSY, PC_EMIT, PC_WAIT};
			default:  w = '{OP_NOP,   C_NONE,     PC_WAIT, PC_WAIT};
		endcase
		return w;
	endfunction

endpackage

### hdl/cycle_count_to_microsecond_timestamp.sv
// Top level: cycle-counter samples to a 64-bit microsecond timestamp.
// Steps for an initialized sample: multiply, load, a 53-step bit-serial divide, accumulate,
// emit; init goes through the init step and emit, a sample before init through zero and emit.
// A new transaction is taken only in the wait step, after the previous one has left the emit step.
// A finished result waits in the output register while the next item is taken.
// Reset: arst_n clears the sequencer, state and output valid; core_clock_hz returns to 84000000.
module cycle_count_to_microsecond_timestamp (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         s_tvalid,
	output logic                         s_tready,
	input  logic [cctm_pkg::CNT_W-1:0]   s_tdata,  // cycle_count
	input  logic                         s_tuser,  // cmd
	output logic                         m_tvalid,
	input  logic                         m_tready,
	output logic [cctm_pkg::TS_W-1:0]    m_tdata,  // elapsed_us
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [cctm_pkg::ADDR_W-1:0]  paddr,
	input  logic [cctm_pkg::DATA_W-1:0]  pwdata,
	output logic [cctm_pkg::DATA_W-1:0]  prdata,
	output logic                         pready
);
	import cctm_pkg::*;

	op_t        op;
	seq_stat_t  stat;

	logic [CNT_W-1:0]  hz_q;
	logic [CNT_W-1:0]  dvs;
	logic              init_q;
	logic              cmd_q;
	logic [CNT_W-1:0]  count_q;
	logic [CNT_W-1:0]  last_q;
	logic [CNT_W-1:0]  keep_rem_q;
	logic [TS_W-1:0]   elapsed_q;
	logic [PROD_W-1:0] prod_q;
	logic [DVD_W-1:0]  quo_q;
	logic [CNT_W-1:0]  rem_q;
	logic [STEP_W-1:0] cnt_q;
	logic [TS_W-1:0]   res_q;
	logic              out_valid_q;
	logic [TS_W-1:0]   out_data_q;

	logic [CNT_W-1:0]  delta;
	logic [CNT_W:0]    trial;
	logic [CNT_W:0]    diff;
	logic              ge;
	logic [CNT_W-1:0]  rem_n;
	logic [TS_W-1:0]   sum;
	logic              out_free;
	logic              cfg_wr;

	// config port
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_CORE_CLOCK_HZ);
	assign prdata = (paddr[2] == REG_CORE_CLOCK_HZ) ? hz_q : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hz_q <= CORE_CLOCK_HZ_RST;
		end else if (cfg_wr) begin
			hz_q <= pwdata;
		end
	end

	assign dvs = (hz_q == '0) ? CNT_W'(1) : hz_q;

	cctm_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.stat   (stat),
		.op     (op)
	);

	assign out_free      = !out_valid_q || m_tready;
	assign stat.in_valid = s_tvalid;
	assign stat.cmd      = (cmd_q == CMD_INIT);
	assign stat.init     = init_q;
	assign stat.div_more = (cnt_q != '0);
	assign stat.out_busy = !out_free;

	assign s_tready = (op == OP_WAIT);

	// datapath
	assign delta = count_q - last_q;
	assign trial = {rem_q, quo_q[DVD_W-1]};
	assign ge    = trial >= {1'b0, dvs};
	assign diff  = trial - {1'b0, dvs};
	assign rem_n = ge ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
	assign sum   = elapsed_q + TS_W'(quo_q);

	always_ff @(posedge clk) begin
		unique case (op)
			OP_WAIT: begin
				if (s_tvalid) begin
					count_q <= s_tdata;
				end
			end
			OP_MUL: begin
				prod_q <= PROD_W'(delta) * PROD_W'(MICROS_PER_SEC);
			end
			OP_LOAD: begin
				quo_q <= {1'b0, prod_q} + DVD_W'(keep_rem_q);
				rem_q <= '0;
			end
			OP_DIV: begin
				quo_q <= {quo_q[DVD_W-2:0], ge};
				rem_q <= rem_n;
			end
			OP_ACCUM: begin
				res_q <= sum;
			end
			OP_INIT, OP_ZERO: begin
				res_q <= '0;
			end
			OP_EMIT: begin
				if (out_free) begin
					out_data_q <= res_q;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_q       <= 1'b0;
			init_q      <= 1'b0;
			last_q      <= '0;
			keep_rem_q  <= '0;
			elapsed_q   <= '0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (op == OP_WAIT && s_tvalid) begin
				cmd_q <= s_tuser;
			end
			if (op == OP_LOAD) begin
				cnt_q <= STEP_W'(DIV_STEPS - 1);
			end else if (op == OP_DIV && cnt_q != '0) begin
				cnt_q <= cnt_q - STEP_W'(1);
			end
			if (op == OP_ACCUM) begin
				elapsed_q  <= sum;
				keep_rem_q <= rem_q;
				last_q     <= count_q;
			end
			if (op == OP_INIT && !init_q) begin
				init_q     <= 1'b1;
				elapsed_q  <= '0;
				keep_rem_q <= '0;
				last_q     <= '0;
			end
			if (op == OP_EMIT && out_free) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

	a_init_sticks: assert property (@(posedge clk) disable iff (!arst_n)
		init_q |=> init_q)
		else $error("initialized flag dropped");

	a_init_cmd_sets: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready && (s_tuser == CMD_INIT)) |-> ##3 init_q)
		else $error("init transaction did not set initialized");

	a_result_from_emit: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(op == OP_EMIT))
		else $error("result appeared outside emit step");

	a_div_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		(op == OP_DIV) |-> (cnt_q <= STEP_W'(DIV_STEPS - 1)))
		else $error("divider step count out of range");

endmodule

### hdl/cctm_seq.sv
// Microcode sequencer: step counter, control ROM and conditional jumps.
module cctm_seq (
	input  logic               clk,
	input  logic               arst_n,
	input  cctm_pkg::seq_stat_t stat,
	output cctm_pkg::op_t      op
);
	import cctm_pkg::*;

	pc_t    pc_q;
	pc_t    pc_n;
	ucode_t word;
	logic   take;

	assign word = ucode_rom(pc_q);
	assign op   = word.op;

	always_comb begin
		unique case (word.cond)
			C_NONE:     take = 1'b0;
			C_NO_INPUT: take = !stat.in_valid;
			C_CMD:      take = stat.cmd;
			C_NOT_INIT: take = !stat.init;
			C_DIV_MORE: take = stat.div_more;
			C_OUT_BUSY: take = stat.out_busy;
			default:    take = 1'b0;
		endcase
	end

	always_comb begin
		pc_n = take ? word.jmp : word.nxt;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= PC_WAIT;
		end else begin
			pc_q <= pc_n;
		end
	end

endmodule

### tb/cycle_count_to_microsecond_timestamp_tb.sv
// Self-checking testbench for the cycle-count to microsecond timestamp converter.
module cycle_count_to_microsecond_timestamp_tb;

	import cctm_pkg::*;

	localparam int WDOG_LIMIT = 20000;
	localparam int WRAP_ITEMS = 200;
	localparam int RAND_ITEMS = 110;

	typedef struct {
		logic             cmd;
		logic [CNT_W-1:0] count;
	} sample_t;

	logic              clk;
	logic              arst_n;
	logic              s_tvalid;
	logic              s_tready;
	logic [CNT_W-1:0]  s_tdata;   // cycle_count
	logic              s_tuser;   // cmd
	logic              m_tvalid;
	logic              m_tready;
	logic [TS_W-1:0]   m_tdata;   // elapsed_us
	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [ADDR_W-1:0] paddr;
	logic [DATA_W-1:0] pwdata;
	logic [DATA_W-1:0] prdata;
	logic              pready;

	cycle_count_to_microsecond_timestamp i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	sample_t         sample_q[$];
	logic [TS_W-1:0] ts_expected[$];
	int unsigned     items_queued;
	int unsigned     results_seen;
	int unsigned     err_cnt;
	int unsigned     idle_cycles;
	logic            s_taken;
	logic            calm;
	int unsigned     src_gap;
	int unsigned     snk_stall;

	// predictor state
	logic [CNT_W-1:0] mdl_hz;
	logic             mdl_init;
	logic [CNT_W-1:0] mdl_last;
	logic [CNT_W-1:0] mdl_rem;
	logic [TS_W-1:0]  mdl_us;

	// stimulus-side view of the counter history
	logic             gen_init;
	logic [CNT_W-1:0] gen_last;

	function automatic logic [TS_W-1:0] predict_timestamp(input logic cmd,
			input logic [CNT_W-1:0] count);
		logic [CNT_W-1:0] delta;
		logic [63:0]      divisor;
		logic [63:0]      dividend;
		if (cmd == CMD_INIT) begin
			if (!mdl_init) begin
				mdl_last = '0;
				mdl_rem  = '0;
				mdl_us   = '0;
				mdl_init = 1'b1;
			end
			return '0;
		end
		if (!mdl_init)
			return '0;
		delta    = count - mdl_last;
		divisor  = (mdl_hz == '0) ? 64'd1 : {32'd0, mdl_hz};
		dividend = {32'd0, delta} * 64'(MICROS_PER_SEC) + {32'd0, mdl_rem};
		mdl_us   = mdl_us + dividend / divisor;
		mdl_rem  = CNT_W'(dividend % divisor);
		mdl_last = count;
		return mdl_us;
	endfunction

	function automatic int unsigned pick_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (calm || r < 60)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 15);
		return $urandom_range(30, 150);
	endfunction

	task automatic push_item(input logic cmd, input logic [CNT_W-1:0] count);
		sample_t it;
		it.cmd   = cmd;
		it.count = count;
		sample_q.push_back(it);
		items_queued++;
		if (cmd == CMD_INIT)
			gen_init = 1'b1;
		else if (gen_init)
			gen_last = count;
	endtask

	task automatic push_random_item();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 5)
			push_item(CMD_INIT, $urandom());
		else if (r < 55)
			push_item(~CMD_INIT, gen_last + $urandom_range(0, 1 << 20));
		else if (r < 70)
			push_item(~CMD_INIT, gen_last - $urandom_range(1, 3));
		else if (r < 95)
			push_item(~CMD_INIT, $urandom());
		else
			push_item(~CMD_INIT, gen_last);
	endtask

	task automatic wait_drained();
		do
			@(negedge clk);
		while (results_seen != items_queued);
	endtask

	task automatic write_core_clock_hz(input logic [DATA_W-1:0] value);
		@(negedge clk);
		psel    <= 1'b1;
		pwrite  <= 1'b1;
		penable <= 1'b0;
		paddr   <= ADDR_W'(4 * REG_CORE_CLOCK_HZ);
		pwdata  <= value;
		@(negedge clk);
		penable <= 1'b1;
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		mdl_hz = value;
		@(posedge clk);
	endtask

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// source side
	always @(negedge clk) begin
		logic    nv;
		sample_t it;
		nv = 1'b0;
		if (arst_n) begin
			if (s_tvalid && !s_taken) begin
				nv = 1'b1;
			end else if (src_gap > 0) begin
				src_gap--;
			end else if (sample_q.size() > 0) begin
				it = sample_q.pop_front();
				nv = 1'b1;
				s_tuser <= it.cmd;
				s_tdata <= it.count;
				src_gap = pick_gap();
			end
		end
		s_tvalid <= nv;
	end

	// sink side
	always @(negedge clk) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else if (snk_stall > 0) begin
			snk_stall--;
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
			snk_stall = pick_gap();
		end
	end

	always @(posedge clk) begin
		logic [TS_W-1:0] exp_ts;
		if (arst_n) begin
			s_taken <= s_tvalid && s_tready;
			if (m_tvalid && m_tready) begin
				results_seen++;
				if (ts_expected.size() == 0) begin
					$error("unexpected transaction: elapsed_us actual %0d", m_tdata);
					err_cnt++;
				end else begin
					exp_ts = ts_expected.pop_front();
					if (m_tdata !== exp_ts) begin
						$error("elapsed_us expected %0d actual %0d", exp_ts, m_tdata);
						err_cnt++;
					end
				end
			end
			if (s_tvalid && s_tready)
				ts_expected.push_back(predict_timestamp(s_tuser, s_tdata));
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= WDOG_LIMIT) begin
				$display("SCOREBOARD MISMATCH");
				$finish;
			end
		end
	end

	initial begin
		logic [DATA_W-1:0] hz_set[7];
		arst_n       = 1'b0;
		s_tvalid     = 1'b0;
		s_tdata      = '0;
		s_tuser      = 1'b0;
		m_tready     = 1'b0;
		psel         = 1'b0;
		penable      = 1'b0;
		pwrite       = 1'b0;
		paddr        = '0;
		pwdata       = '0;
		s_taken      = 1'b0;
		calm         = 1'b0;
		src_gap      = 0;
		snk_stall    = 0;
		items_queued = 0;
		results_seen = 0;
		err_cnt      = 0;
		idle_cycles  = 0;
		mdl_hz       = CORE_CLOCK_HZ_RST;
		mdl_init     = 1'b0;
		mdl_last     = '0;
		mdl_rem      = '0;
		mdl_us       = '0;
		gen_init     = 1'b0;
		gen_last     = '0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// reset divisor: samples before init, init, repeated init, counter wrap
		@(posedge clk);
		push_item(~CMD_INIT, 32'd0);
		push_item(~CMD_INIT, 32'hFFFF_FFFF);
		push_item(CMD_INIT, 32'h5A5A_5A5A);
		push_item(CMD_INIT, 32'hFFFF_FFFF);
		push_item(~CMD_INIT, 32'd0);
		push_item(~CMD_INIT, 32'd1);
		push_item(~CMD_INIT, 32'hFFFF_FFFF);
		push_item(~CMD_INIT, 32'd0);
		push_item(~CMD_INIT, 32'd12345678);
		wait_drained();

		// largest divisor builds up a large remainder
		write_core_clock_hz(32'hFFFF_FFFF);
		push_item(~CMD_INIT, gen_last + 32'd1);
		push_item(~CMD_INIT, gen_last + 32'd7);
		push_item(~CMD_INIT, gen_last + 32'h8000_0000);
		push_item(~CMD_INIT, gen_last + 32'hFFFF_FFFF);
		wait_drained();

		// kept remainder above the new divisor
		write_core_clock_hz(32'd3);
		push_item(~CMD_INIT, gen_last);
		push_item(~CMD_INIT, gen_last + 32'd1);
		push_item(CMD_INIT, 32'd0);
		wait_drained();

		write_core_clock_hz(32'd1);
		push_item(~CMD_INIT, gen_last - 32'd1);
		push_item(~CMD_INIT, gen_last);
		wait_drained();

		// zero divisor with maximum deltas
		write_core_clock_hz(32'd0);
		calm = 1'b1;
		for (int i = 0; i < WRAP_ITEMS; i++)
			push_item(~CMD_INIT, gen_last - 32'd1);
		wait_drained();

		hz_set[0] = 32'd1;
		hz_set[1] = 32'hFFFF_FFFF;
		hz_set[2] = CORE_CLOCK_HZ_RST;
		hz_set[3] = 32'd1000000;
		hz_set[4] = $urandom();
		hz_set[5] = $urandom_range(2, 1000);
		hz_set[6] = 32'd0;
		for (int p = 0; p < 7; p++) begin
			write_core_clock_hz(hz_set[p]);
			calm = (p % 3 == 2);
			for (int i = 0; i < RAND_ITEMS; i++)
				push_random_item();
			wait_drained();
		end

		repeat (80) @(posedge clk);
		if (ts_expected.size() != 0) begin
			$error("%0d timestamp transactions never arrived", ts_expected.size());
			err_cnt++;
		end
		if (err_cnt == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

### sim.f
hdl/cctm_pkg.sv
hdl/cctm_seq.sv
hdl/cycle_count_to_microsecond_timestamp.sv
tb/cycle_count_to_microsecond_timestamp_tb.sv
